@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Both sample on i_clk and are disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLB_AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CLB_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/clb_pkg.sv @@
package clb_pkg;

    localparam int LINE_SIZE = 32;
    localparam int CNT_W     = $clog2(LINE_SIZE);
    localparam int ADDR_W    = $clog2(2 * LINE_SIZE);
    localparam int PADDR_W   = 3;
    localparam int APB_DW    = 32;

    typedef logic [7:0]        t_byte;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;

    // Highest fill count a line may reach.
    localparam t_cnt LAST_POS = t_cnt'(LINE_SIZE - 1);
    localparam t_cnt F3_LEN   = t_cnt'(4);

    // Register index, taken from the word-address bit of paddr.
    localparam logic REG_ECHO = 1'b0;

    localparam logic [1:0] OP_RX    = 2'd0;
    localparam logic [1:0] OP_FETCH = 2'd1;
    localparam logic [1:0] OP_PEEK  = 2'd2;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FILLING = 2'd1;
    localparam logic [1:0] ST_READY   = 2'd2;

    localparam t_byte CH_NUL    = 8'h00;
    localparam t_byte CH_BS     = 8'h08;
    localparam t_byte CH_LF     = 8'h0A;
    localparam t_byte CH_CR     = 8'h0D;
    localparam t_byte CH_SPACE  = 8'h20;
    localparam t_byte CH_BANG   = 8'h21;
    localparam t_byte CH_ONE    = 8'h31;
    localparam t_byte CH_THREE  = 8'h33;
    localparam t_byte CH_LBRACK = 8'h5B;
    localparam t_byte CH_TILDE  = 8'h7E;
    localparam t_byte CH_DEL    = 8'h7F;

    // Output plan for one accepted item: fixed head bytes, a stored line, CR LF tail.
    typedef struct packed {
        logic [1:0]  head_cnt;
        t_byte [2:0] head;
        logic [1:0]  head_kind;
        t_cnt        line_len;
        logic        line_sel;
        logic [1:0]  line_kind;
        logic        tail;
    } t_plan;

    typedef struct packed {
        logic  en;
        t_addr addr;
        t_byte data;
    } t_wr;

    // Byte expected at each position of the re-queue sequence "[13~".
    function automatic t_byte f3_char(input logic [1:0] pos);
        t_byte ch;
        case (pos)
            2'd0: ch = CH_LBRACK;
            2'd1: ch = CH_ONE;
            2'd2: ch = CH_THREE;
            default: ch = CH_TILDE;
        endcase
        return ch;
    endfunction

    function automatic t_addr line_addr(input logic sel, input t_cnt idx);
        return sel ? (t_addr'(LINE_SIZE) + t_addr'(idx)) : t_addr'(idx);
    endfunction

endpackage

@@ hdl/clb_in_if.sv @@
interface clb_in_if;
    import clb_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] operation;
    t_byte      rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

@@ hdl/clb_out_if.sv @@
interface clb_out_if;
    import clb_pkg::*;

    logic       valid;
    logic       ready;
    t_byte      out_byte;
    logic [1:0] out_kind;
    logic       last;

    modport source (output valid, output out_byte, output out_kind, output last, input ready);
    modport sink (input valid, input out_byte, input out_kind, input last, output ready);
endinterface

@@ hdl/clb_emit.sv @@
`include "assert_macros.svh"

module clb_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  clb_pkg::t_plan  i_plan,
    input  clb_pkg::t_wr    i_wr,
    output logic            o_busy,
    clb_out_if.source       o_out
);
    import clb_pkg::*;

    localparam logic [1:0] SQ_IDLE = 2'd0;
    localparam logic [1:0] SQ_HEAD = 2'd1;
    localparam logic [1:0] SQ_LINE = 2'd2;
    localparam logic [1:0] SQ_TAIL = 2'd3;

    t_byte      r_mem [2*LINE_SIZE];
    t_byte      r_q;

    logic [1:0] r_sq;
    t_cnt       r_idx;
    t_plan      r_plan;

    logic       r_s1_valid;
    logic       r_s1_mem;
    t_byte      r_s1_byte;
    logic [1:0] r_s1_kind;
    logic       r_s1_last;

    logic       r_o_valid;
    t_byte      r_o_byte;
    logic [1:0] r_o_kind;
    logic       r_o_last;

    logic       out_free;
    logic       s1_move;
    logic       s1_free;
    logic       gen_go;
    logic       head_end;
    logic       line_end;
    t_byte      g_byte;
    logic [1:0] g_kind;
    logic       g_mem;
    logic       g_last;
    logic       rd_en;
    t_addr      rd_addr;

    assign out_free = !r_o_valid || o_out.ready;
    assign s1_move  = r_s1_valid && out_free;
    assign s1_free  = !r_s1_valid || out_free;
    assign gen_go   = (r_sq != SQ_IDLE) && s1_free;
    assign head_end = (r_idx == t_cnt'(r_plan.head_cnt - 2'd1));
    assign line_end = (r_idx == r_plan.line_len - 1'b1);
    assign rd_en    = gen_go && (r_sq == SQ_LINE);
    assign rd_addr  = line_addr(r_plan.line_sel, r_idx);
    assign o_busy   = (r_sq != SQ_IDLE);

    always_comb begin
        g_byte = CH_NUL;
        g_kind = KIND_ECHO;
        g_mem  = 1'b0;
        g_last = 1'b0;
        case (r_sq)
            SQ_HEAD: begin
                g_byte = r_plan.head[r_idx[1:0]];
                g_kind = r_plan.head_kind;
                g_last = head_end && (r_plan.line_len == '0) && !r_plan.tail;
            end
            SQ_LINE: begin
                g_mem  = 1'b1;
                g_kind = r_plan.line_kind;
                g_last = line_end && !r_plan.tail;
            end
            SQ_TAIL: begin
                g_byte = r_idx[0] ? CH_LF : CH_CR;
                g_last = r_idx[0];
            end
            default: begin
                g_byte = CH_NUL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (rd_en) begin
            r_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq  <= SQ_IDLE;
            r_idx <= '0;
        end else if (i_start) begin
            r_idx <= '0;
            if (i_plan.head_cnt != 2'd0) begin
                r_sq <= SQ_HEAD;
            end else if (i_plan.line_len != '0) begin
                r_sq <= SQ_LINE;
            end else begin
                r_sq <= SQ_IDLE;
            end
        end else if (gen_go) begin
            case (r_sq)
                SQ_HEAD: begin
                    if (head_end) begin
                        r_idx <= '0;
                        r_sq  <= (r_plan.line_len != '0) ? SQ_LINE : SQ_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                SQ_LINE: begin
                    if (line_end) begin
                        r_idx <= '0;
                        r_sq  <= r_plan.tail ? SQ_TAIL : SQ_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                SQ_TAIL: begin
                    if (r_idx[0]) begin
                        r_idx <= '0;
                        r_sq  <= SQ_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: begin
                    r_sq <= SQ_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_plan <= i_plan;
        end
    end

    // Stage one holds a word whose byte may still sit in the memory read register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (gen_go) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen_go) begin
            r_s1_mem  <= g_mem;
            r_s1_byte <= g_byte;
            r_s1_kind <= g_kind;
            r_s1_last <= g_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_move) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_byte <= r_s1_mem ? r_q : r_s1_byte;
            r_o_kind <= r_s1_kind;
            r_o_last <= r_s1_last;
        end
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.out_byte = r_o_byte;
    assign o_out.out_kind = r_o_kind;
    assign o_out.last     = r_o_last;

    `CLB_AST_SAME(a_start_idle, i_start, r_sq == SQ_IDLE, "plan loaded while sequencer busy")
    `CLB_AST_NEXT(a_rd_lands, rd_en, r_s1_valid && r_s1_mem, "line read did not reach stage one")
    `CLB_AST_NEXT(a_s1_hold, r_s1_valid && !out_free, r_s1_valid && $stable(r_s1_byte) && $stable(r_s1_last), "stalled stage one word changed")

endmodule

@@ hdl/command_line_double_buffer_top.sv @@
// The first word of an item goes through the sequencer, stage one and the output register to o_out.
// The input is not ready while the sequencer still has words of an item to give, so a new item
// waits for that; when o_out does not stall, words stream one per cycle, line bytes from the read port.
// Items that give no words are taken on consecutive cycles.
// Reset (synchronous, active low) makes both buffers done and empty, buffer zero active and
// echo on; the line memory is not cleared, as bytes are only read below a buffer's fill count.
`include "assert_macros.svh"

module command_line_double_buffer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    clb_in_if.sink                        i_in,
    clb_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [clb_pkg::PADDR_W-1:0]   paddr,
    input  logic [clb_pkg::APB_DW-1:0]    pwdata,
    output logic [clb_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import clb_pkg::*;

    logic                  r_echo;
    logic                  r_act;
    logic [1:0][1:0]       r_stat;
    t_cnt [1:0]            r_fill;
    // Per buffer, bit i is set when stored byte i matches "[13~" at that position.
    logic [1:0][3:0]       r_m;

    logic                  n_act;
    logic [1:0][1:0]       n_stat;
    t_cnt [1:0]            n_fill;
    logic [1:0][3:0]       n_m;

    logic                  in_acc;
    logic                  emit_busy;
    t_plan                 plan;
    t_wr                   wr;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = !emit_busy;

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_ECHO) ? {{(APB_DW-1){1'b0}}, r_echo} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo <= 1'b1;
        end else if (psel && penable && pwrite && (paddr[PADDR_W-1] == REG_ECHO)) begin
            r_echo <= pwdata[0];
        end
    end

    always_comb begin
        logic  a;
        t_byte c;
        t_cnt  cnt;

        n_act  = r_act;
        n_stat = r_stat;
        n_fill = r_fill;
        n_m    = r_m;
        plan   = '0;
        wr     = '0;
        a      = r_act;
        c      = i_in.rx_byte;
        cnt    = '0;

        if (in_acc) begin
            case (i_in.operation)
                OP_RX: begin
                    if ((c != CH_NUL) && !c[7] && (r_stat[a] != ST_READY)) begin
                        if (n_stat[a] == ST_DONE) begin
                            n_fill[a] = '0;
                            n_stat[a] = ST_FILLING;
                        end

                        if (c == CH_BANG) begin
                            // Recall: swap to the other buffer and edit its line.
                            if (n_fill[a] == '0) begin
                                n_act      = ~n_act;
                                a          = n_act;
                                n_stat[a]  = ST_FILLING;
                                n_stat[~a] = ST_DONE;
                                if (r_echo) begin
                                    plan.line_len  = n_fill[a];
                                    plan.line_sel  = a;
                                    plan.line_kind = KIND_ECHO;
                                end
                            end
                        end else if ((c == CH_DEL) || (c == CH_BS)) begin
                            if (n_fill[a] != '0) begin
                                if (r_echo) begin
                                    plan.head_cnt  = 2'd3;
                                    plan.head[0]   = CH_BS;
                                    plan.head[1]   = CH_SPACE;
                                    plan.head[2]   = CH_BS;
                                    plan.head_kind = KIND_ECHO;
                                end
                                n_fill[a] = n_fill[a] - 1'b1;
                            end
                        end else if ((c >= CH_SPACE) && (c <= CH_TILDE)) begin
                            cnt = n_fill[a];
                            if ((cnt < LAST_POS) && !((cnt == '0) && (c == CH_SPACE))) begin
                                wr.en   = 1'b1;
                                wr.addr = line_addr(a, cnt);
                                wr.data = c;
                                if (cnt < F3_LEN) begin
                                    n_m[a][cnt[1:0]] = (c == f3_char(cnt[1:0]));
                                end
                                n_fill[a] = cnt + 1'b1;
                                // Lines that open with '[' are escape sequences and stay silent.
                                if (r_echo && !n_m[a][0]) begin
                                    plan.head_cnt  = 2'd1;
                                    plan.head[0]   = c;
                                    plan.head_kind = KIND_ECHO;
                                end
                            end
                        end

                        if ((c == CH_CR) || (c == CH_LF)) begin
                            if (n_fill[a] != '0) begin
                                if (r_echo) begin
                                    plan.head_cnt  = 2'd2;
                                    plan.head[0]   = CH_CR;
                                    plan.head[1]   = CH_LF;
                                    plan.head_kind = KIND_ECHO;
                                end
                                n_stat[a] = ST_READY;
                                if (n_stat[~a] != ST_READY) begin
                                    n_act     = ~n_act;
                                    a         = n_act;
                                    n_stat[a] = ST_DONE;
                                end
                            end
                        end

                        if ((n_fill[a] == F3_LEN) && (&n_m[a])) begin
                            // Re-queue the previous command held in the other buffer.
                            if ((n_stat[~a] == ST_DONE) && (n_fill[~a] != '0)) begin
                                if (r_echo) begin
                                    plan.line_len  = n_fill[~a];
                                    plan.line_sel  = ~a;
                                    plan.line_kind = KIND_ECHO;
                                    plan.tail      = 1'b1;
                                end
                                n_stat[~a] = ST_READY;
                            end
                            n_fill[a] = '0;
                            n_stat[a] = ST_DONE;
                        end else if (n_m[a][0] && (n_fill[a] > F3_LEN)) begin
                            n_fill[a] = '0;
                            n_stat[a] = ST_DONE;
                        end
                    end
                end
                OP_FETCH, OP_PEEK: begin
                    if ((r_stat[~a] != ST_READY) || (r_fill[~a] == '0)) begin
                        plan.head_cnt  = 2'd1;
                        plan.head[0]   = CH_NUL;
                        plan.head_kind = KIND_NONE;
                    end else begin
                        plan.line_len  = r_fill[~a];
                        plan.line_sel  = ~a;
                        plan.line_kind = KIND_CMD;
                        if (i_in.operation == OP_FETCH) begin
                            n_stat[~a] = ST_DONE;
                            if (r_stat[a] == ST_READY) begin
                                n_act = ~r_act;
                            end
                        end
                    end
                end
                default: begin
                    plan = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_stat <= {ST_DONE, ST_DONE};
            r_fill <= '0;
            r_m    <= '0;
        end else begin
            r_act  <= n_act;
            r_stat <= n_stat;
            r_fill <= n_fill;
            r_m    <= n_m;
        end
    end

    clb_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_plan  (plan),
        .i_wr    (wr),
        .o_busy  (emit_busy),
        .o_out   (o_out)
    );

    `CLB_AST_SAME(a_ready_order, r_stat[r_act] == ST_READY, r_stat[~r_act] == ST_READY, "active buffer ready ahead of the other")
    `CLB_AST_NEXT(a_null_quiet, in_acc && (i_in.operation == OP_RX) && (i_in.rx_byte == CH_NUL), $stable(r_act) && $stable(r_stat) && $stable(r_fill), "null byte changed line state")
    `CLB_AST_NEXT(a_fetch_done, in_acc && (i_in.operation == OP_FETCH) && (r_stat[~r_act] == ST_READY) && (r_fill[~r_act] != '0), r_stat[~$past(r_act)] == ST_DONE, "fetched buffer not released")

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    import clb_pkg::*;

    localparam logic [1:0]         OP_UNUSED = 2'd3;
    localparam logic [PADDR_W-1:0] ECHO_ADDR = PADDR_W'({REG_ECHO, 2'b00});
    localparam int                 MAX_WORDS = LINE_SIZE + 1;

    typedef struct packed {
        t_byte      data;
        logic [1:0] kind;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic [1:0] op;
        t_byte      ch;
        logic       fixed;
        logic [5:0] n_words;
        t_byte      w_data;
        logic [1:0] w_kind;
    } dir_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    clb_in_if  in_ch ();
    clb_out_if out_ch ();

    command_line_double_buffer_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the two line buffers and the echo setting.
    t_byte      line_mem [0:1][0:LINE_SIZE-1];
    int         fill_len [0:1];
    logic [1:0] buf_state [0:1];
    int         active_buf;
    logic       echo_on;

    out_word_t  item_words[$];
    out_word_t  pending_words[$];
    int         live_items = 0;
    int         err_count = 0;
    logic       hold_request = 1'b0;
    logic       burst = 1'b0;
    dir_row_t   dir_rows [0:24];

    initial begin
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    initial begin
        #200_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
    endfunction

    function automatic void put_word(input t_byte data, input logic [1:0] kind);
        out_word_t w;
        w.data = data;
        w.kind = kind;
        w.last = 1'b0;
        if (item_words.size() < MAX_WORDS) begin
            item_words.push_back(w);
        end
    endfunction

    function automatic void put_line(input int sel, input logic [1:0] kind);
        int len;
        len = (fill_len[sel] > LINE_SIZE) ? LINE_SIZE : fill_len[sel];
        for (int i = 0; i < len; i++) begin
            put_word(line_mem[sel][i], kind);
        end
    endfunction

    function automatic logic holds_requeue(input int sel);
        return fill_len[sel] == 4 && line_mem[sel][0] == CH_LBRACK &&
               line_mem[sel][1] == CH_ONE && line_mem[sel][2] == CH_THREE &&
               line_mem[sel][3] == CH_TILDE;
    endfunction

    function automatic void line_rx(input t_byte c);
        int a;
        int b;
        int cnt;
        a = active_buf;
        if (c == CH_NUL || c > CH_DEL || buf_state[a] == ST_READY) begin
            return;
        end
        if (buf_state[a] == ST_DONE) begin
            fill_len[a] = 0;
            buf_state[a] = ST_FILLING;
        end

        if (c == CH_BANG) begin
            // Recall only on an empty line; the other buffer becomes the edited one.
            if (fill_len[a] == 0) begin
                active_buf = 1 - active_buf;
                a = active_buf;
                buf_state[a] = ST_FILLING;
                buf_state[1 - a] = ST_DONE;
                if (echo_on) begin
                    put_line(a, KIND_ECHO);
                end
            end
        end else if (c == CH_DEL || c == CH_BS) begin
            if (fill_len[a] != 0) begin
                if (echo_on) begin
                    put_word(CH_BS, KIND_ECHO);
                    put_word(CH_SPACE, KIND_ECHO);
                    put_word(CH_BS, KIND_ECHO);
                end
                fill_len[a]--;
            end
        end else if (c >= CH_SPACE && c <= CH_TILDE) begin
            cnt = fill_len[a];
            if (cnt < LINE_SIZE - 1 && !(cnt == 0 && c == CH_SPACE)) begin
                line_mem[a][cnt] = c;
                fill_len[a] = cnt + 1;
                if (echo_on && line_mem[a][0] != CH_LBRACK) begin
                    put_word(c, KIND_ECHO);
                end
            end
        end

        if ((c == CH_CR || c == CH_LF) && fill_len[a] != 0) begin
            if (echo_on) begin
                put_word(CH_CR, KIND_ECHO);
                put_word(CH_LF, KIND_ECHO);
            end
            buf_state[a] = ST_READY;
            if (buf_state[1 - a] != ST_READY) begin
                active_buf = 1 - active_buf;
                a = active_buf;
                buf_state[a] = ST_DONE;
            end
        end

        b = 1 - a;
        if (holds_requeue(a)) begin
            if (buf_state[b] == ST_DONE && fill_len[b] != 0) begin
                if (echo_on) begin
                    put_line(b, KIND_ECHO);
                    put_word(CH_CR, KIND_ECHO);
                    put_word(CH_LF, KIND_ECHO);
                end
                buf_state[b] = ST_READY;
            end
            fill_len[a] = 0;
            buf_state[a] = ST_DONE;
        end else if (line_mem[a][0] == CH_LBRACK && fill_len[a] > 4) begin
            fill_len[a] = 0;
            buf_state[a] = ST_DONE;
        end
    endfunction

    function automatic void line_fetch(input logic advance);
        int a;
        int b;
        a = active_buf;
        b = 1 - a;
        if (buf_state[b] != ST_READY || fill_len[b] == 0) begin
            put_word(CH_NUL, KIND_NONE);
            return;
        end
        put_line(b, KIND_CMD);
        if (advance) begin
            buf_state[b] = ST_DONE;
            if (buf_state[a] == ST_READY) begin
                active_buf = 1 - active_buf;
            end
        end
    endfunction

    function automatic void predict_words(input logic [1:0] op, input t_byte ch);
        out_word_t w;
        item_words.delete();
        case (op)
            OP_RX: begin
                line_rx(ch);
            end
            OP_FETCH: begin
                line_fetch(1'b1);
            end
            OP_PEEK: begin
                line_fetch(1'b0);
            end
            default: begin
                // The unused operation gives no words and leaves the lines alone.
            end
        endcase
        for (int i = 0; i < item_words.size(); i++) begin
            w = item_words[i];
            w.last = (i == item_words.size() - 1);
            pending_words.push_back(w);
        end
        live_items++;
    endfunction

    // Called at a rising edge; returns at a rising edge.
    task automatic send_word(input logic [1:0] op, input t_byte ch);
        int n;
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.rx_byte   <= ch;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        predict_words(op, ch);
        if (!burst && $urandom_range(0, 1) == 1) begin
            n = gap_len();
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic set_echo(input logic val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ECHO_ADDR;
        pwdata  <= APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        echo_on = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        if (prdata !== APB_DW'(val)) begin
            $error("echo_enable: expected %0h, got %0h", APB_DW'(val), prdata);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits for every expected word, then lets a word-less item finish inside the block.
    task automatic drain_out();
        in_ch.valid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_byte printable();
        return t_byte'($urandom_range(32, 126));
    endfunction

    task automatic line_sequence();
        int r;
        int len;
        r = $urandom_range(0, 99);
        burst = ($urandom_range(0, 3) == 0);
        if (r < 45) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 10);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_word(OP_RX, $urandom_range(0, 1) ? CH_BS : CH_DEL);
                end else begin
                    send_word(OP_RX, printable());
                end
            end
            if ($urandom_range(0, 9) != 0) begin
                send_word(OP_RX, $urandom_range(0, 1) ? CH_CR : CH_LF);
            end
        end else if (r < 53) begin
            send_word(OP_RX, CH_BANG);
            len = $urandom_range(0, 3);
            for (int i = 0; i < len; i++) begin
                send_word(OP_RX, printable());
            end
            send_word(OP_RX, CH_CR);
        end else if (r < 60) begin
            send_word(OP_RX, CH_LBRACK);
            send_word(OP_RX, CH_ONE);
            send_word(OP_RX, CH_THREE);
            send_word(OP_RX, CH_TILDE);
        end else if (r < 65) begin
            // Escape-like junk that the block throws away once it runs past four bytes.
            send_word(OP_RX, CH_LBRACK);
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                send_word(OP_RX, printable());
            end
        end else if (r < 88) begin
            send_word($urandom_range(0, 2) ? OP_FETCH : OP_PEEK, t_byte'($urandom_range(0, 255)));
        end else if (r < 97) begin
            send_word(2'($urandom_range(0, 3)), t_byte'($urandom_range(0, 255)));
        end else begin
            in_ch.valid <= 1'b0;
            wait (pending_words.size() == 0);
            @(posedge i_clk);
        end
    endtask

    task automatic run_lines(input int target);
        int start;
        start = live_items;
        while (live_items - start < target) begin
            line_sequence();
        end
        burst = 1'b0;
    endtask

    initial begin : out_stall
        int hold_left;
        int run_left;
        hold_left = 0;
        run_left  = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 399;
                out_ch.ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                out_ch.ready <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                hold_left = gap_len() - 1;
                out_ch.ready <= 1'b0;
            end else begin
                run_left = $urandom_range(0, 30);
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : out_check
        out_word_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_words.size() == 0) begin
                $error("out word with nothing expected: byte %0h kind %0d",
                       out_ch.out_byte, out_ch.out_kind);
                err_count++;
            end else begin
                want = pending_words.pop_front();
                if (out_ch.out_byte !== want.data) begin
                    $error("out_byte: expected %0h, got %0h", want.data, out_ch.out_byte);
                    err_count++;
                end
                if (out_ch.out_kind !== want.kind) begin
                    $error("out_kind: expected %0d, got %0d", want.kind, out_ch.out_kind);
                    err_count++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, out_ch.last);
                    err_count++;
                end
            end
        end
    end

    initial begin : main
        dir_row_t row;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_RX;
        in_ch.rx_byte   = CH_NUL;
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < LINE_SIZE; i++) begin
                line_mem[s][i] = CH_NUL;
            end
            fill_len[s]  = 0;
            buf_state[s] = ST_DONE;
        end
        active_buf = 0;
        echo_on    = 1'b1;

        // Fixed rows check the word count and the first word; the predictor supplies the rest.
        dir_rows = '{
            '{OP_PEEK,   CH_NUL,    1'b1, 6'd1, CH_NUL,   KIND_NONE},
            '{OP_FETCH,  CH_NUL,    1'b1, 6'd1, CH_NUL,   KIND_NONE},
            '{OP_UNUSED, CH_NUL,    1'b1, 6'd0, CH_NUL,   KIND_ECHO},
            '{OP_RX,     CH_NUL,    1'b1, 6'd0, CH_NUL,   KIND_ECHO},
            '{OP_RX,     8'hFF,     1'b1, 6'd0, CH_NUL,   KIND_ECHO},
            '{OP_RX,     CH_SPACE,  1'b1, 6'd0, CH_NUL,   KIND_ECHO},
            '{OP_RX,     "a",       1'b1, 6'd1, "a",      KIND_ECHO},
            '{OP_RX,     CH_BANG,   1'b1, 6'd0, CH_NUL,   KIND_ECHO},
            '{OP_RX,     CH_TILDE,  1'b1, 6'd1, CH_TILDE, KIND_ECHO},
            '{OP_RX,     CH_BS,     1'b1, 6'd3, CH_BS,    KIND_ECHO},
            '{OP_RX,     CH_DEL,    1'b1, 6'd3, CH_BS,    KIND_ECHO},
            '{OP_RX,     "b",       1'b1, 6'd1, "b",      KIND_ECHO},
            '{OP_RX,     CH_CR,     1'b1, 6'd2, CH_CR,    KIND_ECHO},
            '{OP_RX,     "x",       1'b0, 6'd0, CH_NUL,   KIND_ECHO},
            '{OP_RX,     CH_LF,     1'b0, 6'd0, CH_NUL,   KIND_ECHO},
            '{OP_RX,     "z",       1'b1, 6'd0, CH_NUL,   KIND_ECHO},
            '{OP_FETCH,  CH_NUL,    1'b0, 6'd0, CH_NUL,   KIND_ECHO},
            '{OP_RX,     CH_BANG,   1'b0, 6'd0, CH_NUL,   KIND_ECHO},
            '{OP_RX,     CH_CR,     1'b0, 6'd0, CH_NUL,   KIND_ECHO},
            '{OP_FETCH,  CH_NUL,    1'b0, 6'd0, CH_NUL,   KIND_ECHO},
            '{OP_RX,     CH_LBRACK, 1'b0, 6'd0, CH_NUL,   KIND_ECHO},
            '{OP_RX,     CH_ONE,    1'b0, 6'd0, CH_NUL,   KIND_ECHO},
            '{OP_RX,     CH_THREE,  1'b0, 6'd0, CH_NUL,   KIND_ECHO},
            '{OP_RX,     CH_TILDE,  1'b0, 6'd0, CH_NUL,   KIND_ECHO},
            '{OP_FETCH,  CH_NUL,    1'b0, 6'd0, CH_NUL,   KIND_ECHO}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_echo(1'b1);
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_word(row.op, row.ch);
            if (row.fixed) begin
                if (item_words.size() != row.n_words) begin
                    $error("word count: expected %0d, got %0d", row.n_words, item_words.size());
                    err_count++;
                end else if (row.n_words != 0 && item_words[0].data != row.w_data) begin
                    $error("out_byte: expected %0h, got %0h", row.w_data, item_words[0].data);
                    err_count++;
                end
            end
        end
        drain_out();

        set_echo(1'b0);
        run_lines(95);
        drain_out();

        set_echo(1'b1);
        hold_request = 1'b1;
        run_lines(95);
        drain_out();

        set_echo(1'b0);
        run_lines(95);
        drain_out();

        set_echo(1'b1);
        hold_request = 1'b1;
        run_lines(95);
        drain_out();

        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ command_line_double_buffer_top.f @@
+incdir+hdl
hdl/clb_pkg.sv
hdl/clb_in_if.sv
hdl/clb_out_if.sv
hdl/clb_emit.sv
hdl/command_line_double_buffer_top.sv
tb/sv/testbench.sv
